### hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising edge of clk while rst_n is high.
`define FSS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("field sync inserter check failed");
// Condition that must never be seen on a rising edge of clk outside reset.
`define FSS_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("field sync inserter forbidden condition seen");
`else
`define FSS_ASSERT(label, prop)
`define FSS_NEVER(label, cond)
`endif

`endif

### hw/rtl/fss_pkg.sv
// Package with the field sync constants, symbol tables and shared types.
`default_nettype none

package fss_pkg;

    localparam int SYMBOLS_PER_GROUP  = 16;
    localparam int SEGMENT_SYMBOLS    = 832;
    localparam int SEGMENTS_PER_FIELD = 312;
    localparam int TAIL_SYMBOLS       = 12;
    localparam int GROUPS_PER_SEGMENT = SEGMENT_SYMBOLS / SYMBOLS_PER_GROUP;

    localparam int PN_LONG          = 511;
    localparam int PN_SHORT         = 63;
    localparam int RESERVED_SYMBOLS = 92;
    localparam int MODE_SYMBOLS     = 24;

    // Symbol offsets of the parts of the field sync segment.
    localparam int LONG_START     = 4;
    localparam int SHORT1_START   = LONG_START + PN_LONG;
    localparam int SHORT2_START   = SHORT1_START + PN_SHORT;
    localparam int SHORT3_START   = SHORT2_START + PN_SHORT;
    localparam int MODE_START     = SHORT3_START + PN_SHORT;
    localparam int RESERVED_START = MODE_START + MODE_SYMBOLS;
    localparam int TAIL_FIRST     = SYMBOLS_PER_GROUP - TAIL_SYMBOLS;

    localparam int GROUP_BITS = 3 * SYMBOLS_PER_GROUP;
    localparam int TAIL_BITS  = 3 * TAIL_SYMBOLS;

    localparam logic [5:0] SYNC_GROUPS    = 6'(GROUPS_PER_SEGMENT);
    localparam logic [5:0] LAST_GROUP     = 6'(GROUPS_PER_SEGMENT - 1);
    localparam logic [8:0] LAST_SEGMENT   = 9'(SEGMENTS_PER_FIELD - 1);

    // Mode word, first transmitted symbol on the left.
    localparam logic [0:MODE_SYMBOLS-1] MODE_WORD = 24'b0000_1010_0101_1111_0101_1010;

    // One column per lane: bit g is that lane's symbol in sync group g.
    typedef logic [SYMBOLS_PER_GROUP-1:0][GROUPS_PER_SEGMENT-1:0] col_array_t;

    // Control that travels with one result towards the output register.
    typedef struct packed {
        logic valid;
        logic sync;
        logic last;
    } emit_ctrl_t;

    // Binary content of the field sync segment in field 1 (tail left at zero).
    function automatic logic [SEGMENT_SYMBOLS-1:0] build_sync_bits();
        logic [PN_LONG-1:0]         pl;
        logic [PN_SHORT-1:0]        ps;
        logic [SEGMENT_SYMBOLS-1:0] b;
        pl = '0;
        pl[7] = 1'b1;
        for (int n = 9; n < PN_LONG; n++) begin
            pl[n] = pl[n-2] ^ pl[n-3] ^ pl[n-5] ^ pl[n-6] ^ pl[n-8] ^ pl[n-9];
        end
        ps = '0;
        ps[0] = 1'b1;
        ps[1] = 1'b1;
        ps[2] = 1'b1;
        ps[5] = 1'b1;
        for (int n = 6; n < PN_SHORT; n++) begin
            ps[n] = ps[n-5] ^ ps[n-6];
        end
        b = '0;
        b[0] = 1'b1;
        b[3] = 1'b1;
        for (int j = 0; j < PN_LONG; j++) begin
            b[LONG_START + j] = pl[j];
        end
        for (int j = 0; j < PN_SHORT; j++) begin
            b[SHORT1_START + j] = ps[j];
            b[SHORT2_START + j] = ps[j];
            b[SHORT3_START + j] = ps[j];
        end
        for (int j = 0; j < MODE_SYMBOLS; j++) begin
            b[MODE_START + j] = MODE_WORD[j];
        end
        for (int j = 0; j < RESERVED_SYMBOLS; j++) begin
            b[RESERVED_START + j] = ps[j % PN_SHORT];
        end
        return b;
    endfunction

    // Symbols that flip in field 2: the middle PN63 run.
    function automatic logic [SEGMENT_SYMBOLS-1:0] build_invert_bits();
        logic [SEGMENT_SYMBOLS-1:0] b;
        b = '0;
        for (int j = 0; j < PN_SHORT; j++) begin
            b[SHORT2_START + j] = 1'b1;
        end
        return b;
    endfunction

    // Regroup a segment's bits into one column per lane.
    function automatic col_array_t build_cols(input logic [SEGMENT_SYMBOLS-1:0] v);
        col_array_t c;
        for (int k = 0; k < SYMBOLS_PER_GROUP; k++) begin
            for (int g = 0; g < GROUPS_PER_SEGMENT; g++) begin
                c[k][g] = v[g * SYMBOLS_PER_GROUP + k];
            end
        end
        return c;
    endfunction

    localparam col_array_t SYNC_COLS = build_cols(build_sync_bits());
    localparam col_array_t INV_COLS  = build_cols(build_invert_bits());

endpackage

`default_nettype wire

### hw/rtl/fss_lane.sv
// One symbol lane: produces its field sync symbol level for the current group.
`default_nettype none

module fss_lane
    import fss_pkg::*;
(
    input  wire logic [5:0]                    group_index,
    input  wire logic [GROUPS_PER_SEGMENT-1:0] column,
    input  wire logic [GROUPS_PER_SEGMENT-1:0] inv_column,
    input  wire logic                          tail_lane,
    input  wire logic                          invert,
    input  wire logic [2:0]                    tail_symbol,
    output logic [2:0]                         level
);

    logic sync_bit;
    logic in_tail;

    // Binary symbol, with the middle PN63 run flipped in field 2.
    assign sync_bit = column[group_index] ^ (invert & inv_column[group_index]);
    assign in_tail  = tail_lane && (group_index == LAST_GROUP);

    // Level 1 for a zero and level 6 for a one; the tail is copied as it was saved.
    always_comb
    begin
        if (in_tail)
        begin
            level = tail_symbol;
        end
        else
        begin
            level = {sync_bit, sync_bit, ~sync_bit};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fss_merge.sv
// Merging stage: picks lane output or pass-through group into the output register.
`default_nettype none

module fss_merge
    import fss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire emit_ctrl_t            emit,
    input  wire logic [GROUP_BITS-1:0] lane_group,
    input  wire logic [GROUP_BITS-1:0] pass_group,
    output logic                       take,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [GROUP_BITS-1:0]      out_group,
    output logic                       is_sync,
    output logic                       last_of_run
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [GROUP_BITS-1:0] out_group_reg;
    logic [GROUP_BITS-1:0] out_group_next;
    logic                  is_sync_reg;
    logic                  last_reg;

    // The register loads whenever it is empty or its transfer completes.
    assign take = !out_valid_reg || !out_stall;

    assign out_valid_next = take ? emit.valid : out_valid_reg;
    assign out_group_next = emit.sync ? lane_group : pass_group;

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (take && emit.valid)
        begin
            out_group_reg <= out_group_next;
            is_sync_reg   <= emit.sync;
            last_reg      <= emit.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_group   = out_group_reg;
    assign is_sync     = is_sync_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

### hw/rtl/field_sync_segment_inserter.sv
// Top level of the field sync segment inserter.
`default_nettype none

// Passes 16-symbol groups of data segments through unchanged and, ahead of
// group 0 of segment 0, inserts a complete 832-symbol field sync segment as
// 52 groups flagged by is_sync; last_of_run marks the final result of each
// input transfer. Ordinary groups flow at one transfer per cycle while the
// output is not stalled; the start-of-field group is passed on after its 52
// sync groups, built one per cycle by sixteen symbol lanes while the output
// is not stalled, and the input is stalled meanwhile. The twelve tail symbols
// come from group 51 of segment 311 of the previous field and read as level
// 0 until such a group has been seen. No start-up delay after reset.
`include "assert_macros.svh"

module field_sync_segment_inserter
    import fss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [GROUP_BITS-1:0] symbol_group,
    input  wire logic [5:0]            group_position,
    input  wire logic [8:0]            segment_number,
    input  wire logic                  second_field,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [GROUP_BITS-1:0]      out_group,
    output logic                       is_sync,
    output logic                       last_of_run
);

    logic                  work_valid_reg;
    logic                  work_valid_next;
    logic [5:0]            work_cnt_reg;
    logic [5:0]            work_cnt_next;
    logic                  work_trig_reg;
    logic                  work_field2_reg;
    logic [GROUP_BITS-1:0] work_group_reg;
    logic [TAIL_BITS-1:0]  saved_tail_reg;

    emit_ctrl_t                          emit;
    logic                                take;
    logic                                advance;
    logic                                finish;
    logic                                accept;
    logic                                start_field;
    logic                                capture_tail;
    logic [SYMBOLS_PER_GROUP-1:0][2:0]   lane_levels;

    // Current emission of the item held in the work stage.
    assign emit.valid = work_valid_reg;
    assign emit.sync  = work_trig_reg && (work_cnt_reg != SYNC_GROUPS);
    assign emit.last  = !emit.sync;

    assign advance  = work_valid_reg && take;
    assign finish   = advance && emit.last;
    assign in_stall = work_valid_reg && !finish;
    assign accept   = in_valid && !in_stall;

    assign start_field  = (group_position == '0) && (segment_number == '0);
    assign capture_tail = (group_position == LAST_GROUP) && (segment_number == LAST_SEGMENT);

    // Work stage sequencing.
    always_comb
    begin
        work_valid_next = work_valid_reg;
        work_cnt_next   = work_cnt_reg;
        if (accept)
        begin
            work_valid_next = 1'b1;
            work_cnt_next   = '0;
        end
        else if (finish)
        begin
            work_valid_next = 1'b0;
        end
        else if (advance)
        begin
            work_cnt_next = work_cnt_reg + 6'd1;
        end
    end

    // Work stage control registers and the saved tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_cnt_reg   <= '0;
            saved_tail_reg <= '0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            work_cnt_reg   <= work_cnt_next;
            if (accept && capture_tail)
            begin
                saved_tail_reg <= symbol_group[GROUP_BITS-1 -: TAIL_BITS];
            end
        end
    end

    // Work stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_trig_reg   <= start_field;
            work_field2_reg <= second_field;
            work_group_reg  <= symbol_group;
        end
    end

    // Sixteen symbol lanes build one sync group per cycle while the output is not stalled.
    for (genvar k = 0; k < SYMBOLS_PER_GROUP; k++)
    begin : g_lane
        logic [2:0] tail_sym;
        if (k >= TAIL_FIRST)
        begin : g_tail
            assign tail_sym = saved_tail_reg[3*(k-TAIL_FIRST) +: 3];
        end
        else
        begin : g_no_tail
            assign tail_sym = '0;
        end

        fss_lane u_lane (
            .group_index (work_cnt_reg),
            .column      (SYNC_COLS[k]),
            .inv_column  (INV_COLS[k]),
            .tail_lane   ((k >= TAIL_FIRST) ? 1'b1 : 1'b0),
            .invert      (work_field2_reg),
            .tail_symbol (tail_sym),
            .level       (lane_levels[k])
        );
    end

    // Merge lanes or pass-through into the output register.
    fss_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .lane_group  (lane_levels),
        .pass_group  (work_group_reg),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_group   (out_group),
        .is_sync     (is_sync),
        .last_of_run (last_of_run)
    );

    // Checks on the sequencing.
    `FSS_ASSERT(a_stall_during_sync, (work_valid_reg && emit.sync) |-> in_stall)
    `FSS_NEVER(a_cnt_range, work_cnt_reg > SYNC_GROUPS)
    `FSS_ASSERT(a_sync_followed, (out_valid && !out_stall && is_sync) |=> out_valid)
    `FSS_ASSERT(a_accept_loads, accept |=> (work_valid_reg && work_cnt_reg == '0))

endmodule

`default_nettype wire

### test/field_sync_segment_inserter_test.sv
// Self-checking testbench for the field sync segment inserter.
`timescale 1ns / 1ps

module field_sync_segment_inserter_test;
    import fss_pkg::*;

    localparam int CLOCK_HALF      = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [2:0] LEVEL_FOR_ZERO = 3'd1;
    localparam logic [2:0] LEVEL_FOR_ONE  = 3'd6;

    // Predicts the groups that leave the block and checks them in order.
    class sync_inserter_scoreboard;
        typedef struct packed {
            logic [GROUP_BITS-1:0] group;
            logic                  sync;
            logic                  last;
        } group_result_t;

        bit                   pn_long [PN_LONG];
        bit                   pn_short [PN_SHORT];
        logic [0:23]          mode_bits;
        logic [TAIL_BITS-1:0] saved_tail;
        group_result_t        expected_groups [$];
        int                   errors;

        function new();
            // PN511 preloaded 000000010, PN63 preloaded 111001, first symbol first.
            for (int n = 0; n < 9; n++)
            begin
                pn_long[n] = (n == 7);
            end
            for (int n = 9; n < PN_LONG; n++)
            begin
                pn_long[n] = pn_long[n-2] ^ pn_long[n-3] ^ pn_long[n-5] ^
                             pn_long[n-6] ^ pn_long[n-8] ^ pn_long[n-9];
            end
            for (int n = 0; n < 6; n++)
            begin
                pn_short[n] = (n != 3) && (n != 4);
            end
            for (int n = 6; n < PN_SHORT; n++)
            begin
                pn_short[n] = pn_short[n-5] ^ pn_short[n-6];
            end
            mode_bits  = 24'b0000_1010_0101_1111_0101_1010;
            saved_tail = '0;
            errors     = 0;
        endfunction

        function logic [2:0] level_of(bit b);
            return b ? LEVEL_FOR_ONE : LEVEL_FOR_ZERO;
        endfunction

        function int pending();
            return expected_groups.size();
        endfunction

        // Works out every result caused by one accepted input transfer.
        function void note_group(logic [GROUP_BITS-1:0] grp, logic [5:0] pos,
                                 logic [8:0] seg, logic field2);
            logic [2:0]            lv [SEGMENT_SYMBOLS];
            logic [GROUP_BITS-1:0] packed_grp;
            group_result_t         entry;
            int                    i;
            if (pos == 6'd0 && seg == 9'd0)
            begin
                // Segment sync pattern 1,0,0,1.
                lv[0] = level_of(1'b1);
                lv[1] = level_of(1'b0);
                lv[2] = level_of(1'b0);
                lv[3] = level_of(1'b1);
                i = 4;
                for (int j = 0; j < PN_LONG; j++)
                begin
                    lv[i] = level_of(pn_long[j]);
                    i++;
                end
                // Three PN63 runs, the middle one inverted in the second field.
                for (int j = 0; j < PN_SHORT; j++)
                begin
                    lv[i] = level_of(pn_short[j]);
                    i++;
                end
                for (int j = 0; j < PN_SHORT; j++)
                begin
                    lv[i] = level_of(pn_short[j] ^ field2);
                    i++;
                end
                for (int j = 0; j < PN_SHORT; j++)
                begin
                    lv[i] = level_of(pn_short[j]);
                    i++;
                end
                for (int j = 0; j < 24; j++)
                begin
                    lv[i] = level_of(mode_bits[j]);
                    i++;
                end
                // Reserved symbols run through PN63 cyclically.
                for (int j = 0; j < RESERVED_SYMBOLS; j++)
                begin
                    lv[i] = level_of(pn_short[j % PN_SHORT]);
                    i++;
                end
                // The tail is copied as raw levels.
                for (int j = 0; j < TAIL_SYMBOLS; j++)
                begin
                    lv[i] = saved_tail[3*j +: 3];
                    i++;
                end
                for (int g = 0; g < GROUPS_PER_SEGMENT; g++)
                begin
                    packed_grp = '0;
                    for (int k = 0; k < SYMBOLS_PER_GROUP; k++)
                    begin
                        packed_grp[3*k +: 3] = lv[g * SYMBOLS_PER_GROUP + k];
                    end
                    entry.group = packed_grp;
                    entry.sync  = 1'b1;
                    entry.last  = 1'b0;
                    expected_groups.push_back(entry);
                end
            end
            // The last group of the last segment keeps its final twelve symbols.
            if (seg == LAST_SEGMENT && pos == LAST_GROUP)
            begin
                saved_tail = grp[GROUP_BITS-1 -: TAIL_BITS];
            end
            entry.group = grp;
            entry.sync  = 1'b0;
            entry.last  = 1'b1;
            expected_groups.push_back(entry);
        endfunction

        // Compares one output transfer with the oldest prediction.
        function void check_group(logic [GROUP_BITS-1:0] grp, logic sync, logic last);
            group_result_t entry;
            if (expected_groups.size() == 0)
            begin
                $error("output transfer with no prediction waiting: out_group %h", grp);
                errors++;
                return;
            end
            entry = expected_groups.pop_front();
            if (grp !== entry.group)
            begin
                $error("out_group expected %h actual %h", entry.group, grp);
                errors++;
            end
            if (sync !== entry.sync)
            begin
                $error("is_sync expected %b actual %b", entry.sync, sync);
                errors++;
            end
            if (last !== entry.last)
            begin
                $error("last_of_run expected %b actual %b", entry.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [GROUP_BITS-1:0] symbol_group;
    logic [5:0]            group_position;
    logic [8:0]            segment_number;
    logic                  second_field;
    logic                  out_valid;
    logic                  out_stall;
    logic [GROUP_BITS-1:0] out_group;
    logic                  is_sync;
    logic                  last_of_run;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    sync_inserter_scoreboard sb;

    field_sync_segment_inserter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol_group   (symbol_group),
        .group_position (group_position),
        .segment_number (segment_number),
        .second_field   (second_field),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_group      (out_group),
        .is_sync        (is_sync),
        .last_of_run    (last_of_run)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLOCK_HALF clk = ~clk;
    end

    // Hard limit on the length of the run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Random back-pressure on the output side.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Both channels are sampled at the edge where a transfer takes place.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_group(symbol_group, group_position, segment_number, second_field);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_group(out_group, is_sync, last_of_run);
            end
        end
    end

    function automatic logic [GROUP_BITS-1:0] random_group();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[GROUP_BITS-1:0];
    endfunction

    // Offers one group, with an optional idle gap first, and waits for its transfer.
    task automatic send_item(input logic [GROUP_BITS-1:0] grp, input logic [5:0] pos,
                             input logic [8:0] seg, input logic field2);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        symbol_group   <= grp;
        group_position <= pos;
        segment_number <= seg;
        second_field   <= field2;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
    endtask

    // Extremes, start of field in both fields, tail capture and out of range tags.
    task automatic run_directed();
        send_item('0, 6'd0, 9'd0, 1'b0);
        send_item('1, 6'd0, 9'd0, 1'b1);
        send_item(48'hFAC688_FAC688, LAST_GROUP, LAST_SEGMENT, 1'b0);
        send_item(48'h5555_5555_5555, 6'd0, 9'd0, 1'b1);
        send_item(48'hAAAA_AAAA_AAAA, 6'd0, 9'd0, 1'b0);
        send_item('1, LAST_GROUP, LAST_SEGMENT, 1'b1);
        send_item('0, 6'd0, 9'd0, 1'b0);
        send_item(random_group(), 6'd52, 9'd0, 1'b0);
        send_item(random_group(), 6'd63, 9'd0, 1'b1);
        send_item(random_group(), 6'd0, 9'd312, 1'b0);
        send_item(random_group(), 6'd0, 9'd511, 1'b1);
        send_item('1, LAST_GROUP, 9'd312, 1'b0);
        send_item(random_group(), 6'd52, LAST_SEGMENT, 1'b0);
        send_item(random_group(), 6'd63, 9'd511, 1'b1);
        send_item(random_group(), 6'd1, 9'd0, 1'b0);
        send_item(random_group(), LAST_GROUP, 9'd0, 1'b1);
        send_item(random_group(), 6'd0, 9'd1, 1'b0);
        send_item(random_group(), 6'd0, LAST_SEGMENT, 1'b1);
        send_item(random_group(), 6'd50, LAST_SEGMENT, 1'b0);
        send_item('0, LAST_GROUP, LAST_SEGMENT, 1'b0);
        send_item('1, 6'd0, 9'd0, 1'b1);
        send_item(random_group(), 6'd0, 9'd0, 1'b0);
    endtask

    // Field boundary runs mixed with single starts, captures and stray tags.
    task automatic run_random(input int count);
        int   start_count;
        int   kind;
        int   first_pos;
        int   extra;
        logic field2;
        start_count = items_sent;
        while (items_sent - start_count < count)
        begin
            kind   = $urandom_range(99);
            field2 = 1'($urandom_range(1));
            if (kind < 30)
            begin
                // End of one field running into the start of the next.
                first_pos = $urandom_range(51, 46);
                extra     = $urandom_range(3);
                for (int p = first_pos; p < GROUPS_PER_SEGMENT; p++)
                begin
                    send_item(random_group(), 6'(p), LAST_SEGMENT, field2);
                end
                if ($urandom_range(3) != 0)
                begin
                    field2 = !field2;
                end
                for (int p = 0; p <= extra; p++)
                begin
                    send_item(random_group(), 6'(p), 9'd0, field2);
                end
            end
            else if (kind < 45)
            begin
                send_item(random_group(), 6'd0, 9'd0, field2);
            end
            else if (kind < 55)
            begin
                send_item(random_group(), LAST_GROUP, LAST_SEGMENT, field2);
            end
            else if (kind < 70)
            begin
                send_item(random_group(), 6'($urandom_range(63)), 9'($urandom_range(511)),
                          field2);
            end
            else
            begin
                send_item(random_group(), 6'($urandom_range(51)),
                          9'($urandom_range(SEGMENTS_PER_FIELD - 1)), field2);
            end
        end
    endtask

    // Reset, directed items, three random phases of different pressure, then drain.
    initial
    begin
        sb = new();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        symbol_group   <= '0;
        group_position <= '0;
        segment_number <= '0;
        second_field   <= 1'b0;
        send_idle_pct  = 16;
        recv_stall_pct = 64;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(ITEMS_PER_PHASE);

        send_idle_pct  = 64;
        recv_stall_pct = 16;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(ITEMS_PER_PHASE);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fss_pkg.sv
hw/rtl/fss_lane.sv
hw/rtl/fss_merge.sv
hw/rtl/field_sync_segment_inserter.sv
test/field_sync_segment_inserter_test.sv
